### rtl/pol_pkg.sv
// Package for the positional ordered list: payload types, command codes and
// status codes. No dependencies.

package pol_pkg;

   localparam int CNT_W      = 6;
   localparam int VAL_W      = 32;
   localparam int CAP_DEFAULT = 32;

   localparam logic [2:0] OP_APPEND   = 3'd0;
   localparam logic [2:0] OP_INSERT   = 3'd1;
   localparam logic [2:0] OP_DEL_HEAD = 3'd2;
   localparam logic [2:0] OP_DEL_TAIL = 3'd3;
   localparam logic [2:0] OP_DEL_POS  = 3'd4;
   localparam logic [2:0] OP_READ     = 3'd5;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_EMPTY = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;
   localparam logic [1:0] ST_RANGE = 2'd3;

   localparam logic [1:0] ACT_HOLD   = 2'd0;
   localparam logic [1:0] ACT_INSERT = 2'd1;
   localparam logic [1:0] ACT_DELETE = 2'd2;
   localparam logic [1:0] ACT_ROTATE = 2'd3;

   typedef struct packed {
      logic [2:0]              opcode;
      logic signed [VAL_W-1:0] value;
      logic [CNT_W-1:0]        position;
   } req_type;

   typedef struct packed {
      logic signed [VAL_W-1:0] read_value;
      logic [1:0]              status;
      logic                    last;
   } rsp_type;

   // Command broadcast to every cell of the chain
   typedef struct packed {
      logic [1:0]              action;
      logic [CNT_W-1:0]        idx;
      logic signed [VAL_W-1:0] value;
   } shift_cmd_type;

endpackage

### rtl/pol_cell.sv
// One storage cell of the list chain. Holds one element and moves it
// to or from its neighbours on the broadcast command. Depends on pol_pkg.

module pol_cell #(
   parameter int INDEX = 0
) (
   input  logic                             clock,
   input  pol_pkg::shift_cmd_type           cmd,
   input  logic signed [pol_pkg::VAL_W-1:0] left_data,
   input  logic signed [pol_pkg::VAL_W-1:0] right_data,
   input  logic signed [pol_pkg::VAL_W-1:0] head_data,
   output logic signed [pol_pkg::VAL_W-1:0] data
);
   import pol_pkg::*;

   localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(INDEX);

   logic signed [VAL_W-1:0] data_ff;
   logic signed [VAL_W-1:0] data_in;

   always_comb begin
      data_in = data_ff;
      unique case (cmd.action)
         ACT_HOLD: begin
            data_in = data_ff;
         end
         ACT_INSERT: begin
            if (MY_IDX == cmd.idx) begin
               data_in = cmd.value;
            end else if (MY_IDX > cmd.idx) begin
               data_in = left_data;
            end
         end
         ACT_DELETE: begin
            if (MY_IDX >= cmd.idx) begin
               data_in = right_data;
            end
         end
         ACT_ROTATE: begin
            // idx marks the tail: it takes the head, the rest move down
            if (MY_IDX == cmd.idx) begin
               data_in = head_data;
            end else if (MY_IDX < cmd.idx) begin
               data_in = right_data;
            end
         end
         default: begin
            data_in = data_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;

endmodule

### rtl/pol_ctrl.sv
// Command decoder, element count, read-out sequencer and response register
// of the ordered list. Depends on pol_pkg.

module pol_ctrl #(
   parameter int CAPACITY = pol_pkg::CAP_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  pol_pkg::req_type                 req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output pol_pkg::rsp_type                 rsp_data,
   input  logic signed [pol_pkg::VAL_W-1:0] head_data,
   output pol_pkg::shift_cmd_type           cmd
);
   import pol_pkg::*;

   localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);
   localparam logic             S_IDLE  = 1'b0;
   localparam logic             S_READ  = 1'b1;

   logic             state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] left_ff, left_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_data_ff, rsp_data_in;

   logic             slot_free;
   logic             accept;
   logic [CNT_W-1:0] pos_m1;

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE) && slot_free;
   assign accept    = req_valid && req_ready;
   assign pos_m1    = req_data.position - CNT_W'(1);

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      left_in      = left_ff;
      rsp_valid_in = slot_free ? 1'b0 : rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      cmd.action   = ACT_HOLD;
      cmd.idx      = '0;
      cmd.value    = req_data.value;

      if (state_ff == S_READ) begin
         if (slot_free) begin
            rsp_valid_in           = 1'b1;
            rsp_data_in.read_value = head_data;
            rsp_data_in.status     = ST_OK;
            rsp_data_in.last       = (left_ff == CNT_W'(1));
            cmd.action             = ACT_ROTATE;
            cmd.idx                = count_ff - CNT_W'(1);
            left_in                = left_ff - CNT_W'(1);
            if (left_ff == CNT_W'(1)) begin
               state_in = S_IDLE;
            end
         end
      end else if (accept) begin
         rsp_valid_in           = 1'b1;
         rsp_data_in.read_value = '0;
         rsp_data_in.status     = ST_OK;
         rsp_data_in.last       = 1'b1;
         unique case (req_data.opcode)
            OP_APPEND: begin
               if (count_ff >= CAP_CNT) begin
                  rsp_data_in.status = ST_FULL;
               end else begin
                  cmd.action = ACT_INSERT;
                  cmd.idx    = count_ff;
                  count_in   = count_ff + CNT_W'(1);
               end
            end
            OP_INSERT: begin
               if (count_ff >= CAP_CNT) begin
                  rsp_data_in.status = ST_FULL;
               end else if (req_data.position == '0) begin
                  rsp_data_in.status = ST_RANGE;
               end else begin
                  cmd.action = ACT_INSERT;
                  cmd.idx    = (pos_m1 > count_ff) ? count_ff : pos_m1;
                  count_in   = count_ff + CNT_W'(1);
               end
            end
            OP_DEL_HEAD: begin
               if (count_ff == '0) begin
                  rsp_data_in.status = ST_EMPTY;
               end else begin
                  cmd.action = ACT_DELETE;
                  cmd.idx    = '0;
                  count_in   = count_ff - CNT_W'(1);
               end
            end
            OP_DEL_TAIL: begin
               if (count_ff == '0) begin
                  rsp_data_in.status = ST_EMPTY;
               end else begin
                  cmd.action = ACT_DELETE;
                  cmd.idx    = count_ff - CNT_W'(1);
                  count_in   = count_ff - CNT_W'(1);
               end
            end
            OP_DEL_POS: begin
               if (count_ff == '0) begin
                  rsp_data_in.status = ST_EMPTY;
               end else if (req_data.position == '0 || req_data.position > count_ff) begin
                  rsp_data_in.status = ST_RANGE;
               end else begin
                  cmd.action = ACT_DELETE;
                  cmd.idx    = pos_m1;
                  count_in   = count_ff - CNT_W'(1);
               end
            end
            OP_READ: begin
               if (count_ff == '0) begin
                  rsp_data_in.status = ST_EMPTY;
               end else begin
                  rsp_valid_in = 1'b0;
                  state_in     = S_READ;
                  left_in      = count_ff;
               end
            end
            default: begin
               rsp_valid_in = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         left_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         left_ff      <= left_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CAP_CNT)
      else $error("element count above capacity");

   a_read_left: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_READ |-> left_ff != '0 && left_ff <= count_ff)
      else $error("read-out counter out of step with count");

   a_read_start: assert property (@(posedge clock) disable iff (reset)
      accept && req_data.opcode == OP_READ && count_ff != '0
      |=> state_ff == S_READ && left_ff == $past(count_ff))
      else $error("read-out did not start");

   a_count_kept_in_read: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_READ |=> $stable(count_ff))
      else $error("count changed during read-out");
`endif

endmodule

### rtl/positional_ordered_list.sv
// Positional ordered list of up to CAPACITY signed 32-bit values, held in a
// chain of cells where every element sits in a cell of its own. Append,
// insert at a 1-based position (past the end appends), delete first, delete
// last and delete at a position each answer with one transfer carrying a
// status (ok, empty, full, out of range) and last set; opcodes 6 and 7
// are dropped without a response. Read out returns one transfer per
// stored element, in list order, with last on the final one, or a single
// empty transfer for an empty list: the chain rotates one place a cycle
// through cell 0 while the response register can take a result, and the
// request side stays stalled meanwhile. A response register parts the two
// channels; a new request is taken when that register is empty or in the
// cycle its waiting result is transferred, so a stalled response stalls the
// request side as well. Element storage is not cleared by reset; only the
// count and the control state are.
// Depends on pol_pkg, pol_cell and pol_ctrl.

module positional_ordered_list #(
   parameter int CAPACITY = pol_pkg::CAP_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  pol_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output pol_pkg::rsp_type rsp_data
);
   import pol_pkg::*;

   shift_cmd_type           cmd;
   logic signed [VAL_W-1:0] cell_data [CAPACITY];
   logic signed [VAL_W-1:0] head_data;

   // Cell 0 is the head of the list
   assign head_data = cell_data[0];

   pol_ctrl #(
      .CAPACITY (CAPACITY)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .head_data (head_data),
      .cmd       (cmd)
   );

   // Build the chain; the ends are tied off to values never used as data
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic signed [VAL_W-1:0] left_data;
      logic signed [VAL_W-1:0] right_data;

      if (i == 0) begin : g_first
         assign left_data = cmd.value;
      end else begin : g_inner_l
         assign left_data = cell_data[i-1];
      end

      if (i == CAPACITY - 1) begin : g_tail
         assign right_data = head_data;
      end else begin : g_inner_r
         assign right_data = cell_data[i+1];
      end

      pol_cell #(
         .INDEX (i)
      ) u_cell (
         .clock      (clock),
         .cmd        (cmd),
         .left_data  (left_data),
         .right_data (right_data),
         .head_data  (head_data),
         .data       (cell_data[i])
      );
   end

endmodule

### tb/tb_positional_ordered_list.sv
`timescale 1ns / 100ps
// Self-checking testbench for positional_ordered_list: directed and random command
// streams, a shadow list that predicts every response, and a checker on the response port.
// Depends on pol_pkg and the positional_ordered_list RTL.

module tb_positional_ordered_list;

   import pol_pkg::*;

   localparam int LIST_CAP     = 32;
   localparam int RESET_CYCLES = 5;
   // Drain margin, sized to cover read out of a full list
   localparam int DRAIN_CYCLES = LIST_CAP + 8;

   // Opcodes the block drops without a response
   localparam logic [2:0] OP_RSVD6 = 3'd6;
   localparam logic [2:0] OP_RSVD7 = 3'd7;

   localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;
   localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;

   // Commands waiting to be driven, filled ahead of time by the stimulus process
   req_type pending_cmd_q[$];
   // Responses the shadow list says must come back, oldest first
   rsp_type expected_rsp_q[$];
   // Shadow copy of the stored elements, head at index 0
   logic signed [VAL_W-1:0] shadow_list[$];

   rsp_type oldest_rsp;
   logic    req_taken;
   int      req_gap_pct;
   int      rsp_stall_pct;
   int      failures;

   positional_ordered_list #(
      .CAPACITY (LIST_CAP)
   ) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Apply one accepted command to the shadow list and queue the responses it must produce
   function automatic void apply_command(input req_type cmd);
      rsp_type    r;
      logic [1:0] st;
      int         slot;
      st = ST_OK;
      r.read_value = '0;
      r.status = ST_OK;
      r.last = 1'b1;
      case (cmd.opcode)
         OP_APPEND: begin
            if (shadow_list.size() >= LIST_CAP) st = ST_FULL;
            else shadow_list.push_back(cmd.value);
         end
         OP_INSERT: begin
            if (shadow_list.size() >= LIST_CAP) begin
               st = ST_FULL;
            end else if (cmd.position == 0) begin
               st = ST_RANGE;
            end else begin
               // a position beyond the tail appends
               slot = int'(cmd.position) - 1;
               if (slot > shadow_list.size()) slot = shadow_list.size();
               shadow_list.insert(slot, cmd.value);
            end
         end
         OP_DEL_HEAD: begin
            if (shadow_list.size() == 0) st = ST_EMPTY;
            else void'(shadow_list.pop_front());
         end
         OP_DEL_TAIL: begin
            if (shadow_list.size() == 0) st = ST_EMPTY;
            else void'(shadow_list.pop_back());
         end
         OP_DEL_POS: begin
            if (shadow_list.size() == 0) st = ST_EMPTY;
            else if (cmd.position == 0 || cmd.position > shadow_list.size()) st = ST_RANGE;
            else shadow_list.delete(int'(cmd.position) - 1);
         end
         OP_READ: begin
            if (shadow_list.size() == 0) begin
               r.status = ST_EMPTY;
               expected_rsp_q.push_back(r);
            end else begin
               foreach (shadow_list[i]) begin
                  r.read_value = shadow_list[i];
                  r.status = ST_OK;
                  r.last = (i == shadow_list.size() - 1);
                  expected_rsp_q.push_back(r);
               end
            end
            return;
         end
         default: return;
      endcase
      r.status = st;
      expected_rsp_q.push_back(r);
   endfunction

   task automatic queue_cmd(input logic [2:0] op, input logic signed [VAL_W-1:0] val,
                            input logic [CNT_W-1:0] pos);
      req_type cmd;
      cmd.opcode = op;
      cmd.value = val;
      cmd.position = pos;
      pending_cmd_q.push_back(cmd);
   endtask

   // Short directed sequence: every opcode, field extremes, the empty list, head, tail, middle and a single element
   task automatic queue_directed();
      queue_cmd(OP_READ,     32'sd0,         6'd0);   // read out of an empty list
      queue_cmd(OP_DEL_HEAD, 32'sd0,         6'd0);   // deletes on an empty list
      queue_cmd(OP_DEL_TAIL, 32'sd0,         6'd0);
      queue_cmd(OP_DEL_POS,  32'sd0,         6'd1);
      queue_cmd(OP_INSERT,   32'sd5,         6'd0);   // insert at position zero
      queue_cmd(OP_INSERT,   VAL_MAX,        6'd5);   // past the end of an empty list
      queue_cmd(OP_APPEND,   VAL_MIN,        6'd63);
      queue_cmd(OP_INSERT,   -32'sd1,        6'd1);   // new head
      queue_cmd(OP_INSERT,   32'sd0,         6'd63);  // far past the tail
      queue_cmd(OP_INSERT,   32'sh5A5A_A5A5, 6'd3);   // middle
      queue_cmd(OP_READ,     32'sd0,         6'd0);
      queue_cmd(OP_DEL_POS,  32'sd0,         6'd0);   // position zero
      queue_cmd(OP_DEL_POS,  32'sd0,         6'd63);  // well outside the list
      queue_cmd(OP_DEL_POS,  32'sd0,         6'd6);   // one past the tail
      queue_cmd(OP_DEL_POS,  32'sd0,         6'd5);   // tail by its position
      queue_cmd(OP_DEL_POS,  32'sd0,         6'd2);
      queue_cmd(OP_RSVD6,    VAL_MAX,        6'd63);  // dropped opcodes
      queue_cmd(OP_RSVD7,    VAL_MIN,        6'd1);
      queue_cmd(OP_DEL_HEAD, 32'sd0,         6'd0);
      queue_cmd(OP_DEL_TAIL, 32'sd0,         6'd0);
      queue_cmd(OP_READ,     32'sd0,         6'd0);   // single element
      queue_cmd(OP_DEL_TAIL, 32'sd0,         6'd0);
      queue_cmd(OP_READ,     32'sd0,         6'd0);
   endtask

   // Random block biased either to fill the list up to full or to drain it to empty
   task automatic queue_random(input int count, input bit grow);
      int                      done;
      int                      roll;
      logic [2:0]              op;
      logic signed [VAL_W-1:0] val;
      logic [CNT_W-1:0]        pos;
      done = 0;
      while (done < count) begin
         roll = $urandom_range(99);
         if (roll < 2)                    op = $urandom_range(1) ? OP_RSVD7 : OP_RSVD6;
         else if (roll < 10)              op = OP_READ;
         else if (roll < (grow ? 50 : 18)) op = OP_APPEND;
         else if (roll < (grow ? 80 : 24)) op = OP_INSERT;
         else if (roll < (grow ? 87 : 50)) op = OP_DEL_HEAD;
         else if (roll < (grow ? 93 : 72)) op = OP_DEL_TAIL;
         else                             op = OP_DEL_POS;

         if ($urandom_range(9) == 0) begin
            case ($urandom_range(3))
               0:       val = VAL_MIN;
               1:       val = VAL_MAX;
               2:       val = '0;
               default: val = '1;
            endcase
         end else begin
            val = $urandom;
         end

         roll = $urandom_range(99);
         if (roll < 75)      pos = CNT_W'($urandom_range(LIST_CAP + 2, 1));
         else if (roll < 85) pos = '0;
         else                pos = CNT_W'($urandom_range(63));

         queue_cmd(op, val, pos);
         // dropped opcodes do not count towards the block length
         if (op != OP_RSVD6 && op != OP_RSVD7) done++;
      end
   endtask

   // Hold until every queued command has been transferred
   task automatic wait_for_send();
      @(posedge clock);
      while (pending_cmd_q.size() != 0 || req_valid) @(posedge clock);
   endtask

   // Driver: change inputs on the falling edge only; advance to the next command
   // once the current one has been transferred at the preceding rising edge
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
         if (!req_valid || req_taken) begin
            if (pending_cmd_q.size() != 0 && $urandom_range(99) >= req_gap_pct) begin
               req_data  <= pending_cmd_q.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: sample both channels on the rising edge, predict on each command
   // transfer and check each response transfer against the oldest expectation
   always @(posedge clock) begin
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_valid && req_ready;
         if (req_valid && req_ready) apply_command(req_data);
         if (rsp_valid && rsp_ready) begin
            if (expected_rsp_q.size() == 0) begin
               $error("response with nothing expected: read_value %0d status %0d last %0b",
                      rsp_data.read_value, rsp_data.status, rsp_data.last);
               failures++;
            end else begin
               oldest_rsp = expected_rsp_q.pop_front();
               if (rsp_data.read_value !== oldest_rsp.read_value) begin
                  $error("read_value mismatch: expected %0d, got %0d",
                         oldest_rsp.read_value, rsp_data.read_value);
                  failures++;
               end
               if (rsp_data.status !== oldest_rsp.status) begin
                  $error("status mismatch: expected %0d, got %0d",
                         oldest_rsp.status, rsp_data.status);
                  failures++;
               end
               if (rsp_data.last !== oldest_rsp.last) begin
                  $error("last mismatch: expected %0b, got %0b",
                         oldest_rsp.last, rsp_data.last);
                  failures++;
               end
            end
         end
      end
   end

   // Stimulus and end of run
   initial begin
      failures      = 0;
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_data      = '0;
      rsp_ready     = 1'b0;
      req_taken     = 1'b0;
      // first phase: sender gaps 30 in 100, receiver stalls 50 in 100
      req_gap_pct   = 30;
      rsp_stall_pct = 50;
      queue_directed();
      queue_random(65, 1'b1);
      queue_random(70, 1'b0);

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock) reset <= 1'b0;
      wait_for_send();

      // second phase: swap the pressure
      req_gap_pct   = 50;
      rsp_stall_pct = 30;
      queue_random(65, 1'b1);
      queue_random(70, 1'b0);
      wait_for_send();

      // last phase: both sides at full rate
      req_gap_pct   = 0;
      rsp_stall_pct = 0;
      queue_random(65, 1'b1);
      queue_random(70, 1'b0);
      wait_for_send();

      // drain outstanding responses, then allow any stray transfer to show up
      while (expected_rsp_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (failures == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest legal run
   initial begin
      #5_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
